>>> hw/rtl/acwg_pkg.sv
// acwg_pkg: shared types and constants of the approximate weight-gradient block
// no dependencies; imported by every module of the block but acwg_ram
`timescale 1ns / 1ps
`default_nettype none
package acwg_pkg;

    // operation carried by one input transfer
    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_PATCH  = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    // classified item passed from the front queue to the back end
    typedef struct packed {
        t_op                op;
        logic signed [31:0] value;
        logic               last;
        logic [10:0]        addr;
    } t_item;

    // configuration port
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 11;
    localparam logic [CFG_IW-1:0] CFG_MAP_WIDTH   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_CONV_STRIDE = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_FILTER_ROWS = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_FILTER_COLS = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_CHANNELS    = 3'd4;

    // front queue
    localparam int QDEPTH = 2;

    // arithmetic widths
    localparam int PROD_W    = 76;   // |peak| * |sum|
    localparam int DVS_W     = 33;   // |peak + eps|
    localparam int QCNT_W    = 7;
    localparam int MUL_STEPS = 44;   // bits of |sum|
    localparam int SZW       = 14;   // patch size
    localparam int BATCH_SHIFT = 7;  // batch of 128
    localparam logic signed [32:0] EPS_Q16 = 33'sd655;
    localparam logic signed [47:0] W48_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] W48_MIN = 48'sh8000_0000_0000;

    // back-end sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_W_START,
        ST_W_MUL,
        ST_W_DIV,
        ST_W_WAIT,
        ST_L_DIV,
        ST_L_WAIT,
        ST_EMIT,
        ST_P_A,
        ST_P_B,
        ST_P_C,
        ST_P_D,
        ST_R_OUT
    } t_state;

endpackage
`default_nettype wire

>>> hw/rtl/approx_conv_weight_grad_top1.sv
// Top-1 approximate weight gradient, top level: front queue and back-end sequencer.
// Gradient sample: a map end adds 44 multiply steps and two divisions before the location
// result, only the location division when the weight is zero or saturated.
// Patch element: store read-modify-write with a split 32x48 multiply.
// Store read: through the registered store port to the result register. Reset is synchronous active low;
// afterwards a clearing pass zeroes the store with input held off.
// depends on acwg_pkg, acwg_front, acwg_back
`timescale 1ns / 1ps
`default_nettype none
module approx_conv_weight_grad_top1
    import acwg_pkg::*;
#(
    parameter int MAX_PATCH = 2048,
    parameter int MAX_MAP   = 4096
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire [CFG_IW-1:0]  i_cfg_idx,
    input  wire [CFG_DW-1:0]  i_cfg_data,
    input  wire               s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire [47:0]        s_axis_tdata,   // sample_value[31:0], entry_addr[42:32]
    input  wire [1:0]         s_axis_tuser,   // func[1:0]
    input  wire               s_axis_tlast,   // map_last
    output logic              m_axis_tvalid,
    input  wire               m_axis_tready,
    output logic [63:0]       m_axis_tdata,   // patch_row[14:0], patch_col[29:15],
                                              // grad_value[61:30]
    output logic [0:0]        m_axis_tuser    // out_kind[0]
);
    t_item       w_item;
    logic        w_item_valid;
    logic        w_item_ready;
    logic        w_hold;
    logic        w_kind;
    logic [14:0] w_row;
    logic [14:0] w_col;
    logic [31:0] w_grad;

    // input side: accept and classify
    acwg_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_hold        (w_hold),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .o_item_valid  (w_item_valid),
        .o_item        (w_item),
        .i_item_ready  (w_item_ready)
    );

    // execution side
    acwg_back #(
        .MAX_PATCH (MAX_PATCH),
        .MAX_MAP   (MAX_MAP)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_item_ready (w_item_ready),
        .o_hold       (w_hold),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_kind   (w_kind),
        .o_patch_row  (w_row),
        .o_patch_col  (w_col),
        .o_grad_value (w_grad)
    );

    // result packing
    assign m_axis_tdata = {2'b00, w_grad, w_col, w_row};
    assign m_axis_tuser = w_kind;
endmodule
`default_nettype wire

>>> hw/rtl/acwg_ram.sv
// acwg_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module acwg_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  wire                                    i_clk,
    input  wire                                    i_we,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire [WIDTH-1:0]                        i_wdata,
    input  wire                                    i_re,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/acwg_div.sv
// acwg_div: iterative restoring divider, one quotient bit per cycle
// depends on acwg_pkg
`timescale 1ns / 1ps
`default_nettype none
module acwg_div
    import acwg_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  wire [PROD_W-1:0]  i_dividend,
    input  wire [DVS_W-1:0]   i_divisor,
    output logic              o_busy,
    output logic              o_done,
    output logic [PROD_W-1:0] o_quo,
    output logic [DVS_W-1:0]  o_rem
);
    logic              r_busy;
    logic              r_done;
    logic [QCNT_W-1:0] r_cnt;
    logic [PROD_W-1:0] r_num;
    logic [PROD_W-1:0] r_quo;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [DVS_W:0]    w_trial;
    logic              w_fit;
    logic              w_last;

    // one trial subtraction per cycle
    assign w_trial = {r_rem, r_num[PROD_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_dvs};
    assign w_last  = r_cnt == QCNT_W'(PROD_W - 1);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[PROD_W-2:0], 1'b0};
            r_quo <= {r_quo[PROD_W-2:0], w_fit};
            r_rem <= w_fit ? DVS_W'(w_trial - {1'b0, r_dvs}) : w_trial[DVS_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

>>> hw/rtl/acwg_front.sv
// acwg_front: accepts input transfers, classifies them and queues them
// depends on acwg_pkg
`timescale 1ns / 1ps
`default_nettype none
module acwg_front
    import acwg_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_hold,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [47:0]  s_axis_tdata,   // sample_value[31:0], entry_addr[42:32]
    input  wire [1:0]   s_axis_tuser,   // func[1:0]
    input  wire         s_axis_tlast,   // map_last
    output logic        o_item_valid,
    output t_item       o_item,
    input  wire         i_item_ready
);
    localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    t_item            r_q [QDEPTH];
    logic [QAW-1:0]   r_wp;
    logic [QAW-1:0]   r_rp;
    logic [QAW:0]     r_cnt;
    t_item            w_in;
    logic             w_push;
    logic             w_pop;

    // decode the transfer into an item
    always_comb begin
        w_in.op    = t_op'(s_axis_tuser);
        w_in.value = s_axis_tdata[31:0];
        w_in.last  = s_axis_tlast;
        w_in.addr  = s_axis_tdata[42:32];
    end

    assign s_axis_tready = !i_hold && (r_cnt != (QAW+1)'(QDEPTH));
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign o_item_valid  = r_cnt != '0;
    assign w_pop         = o_item_valid && i_item_ready;
    assign o_item        = r_q[r_rp];

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == QAW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == QAW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_in;
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/acwg_back.sv
// acwg_back: map tracking, weight computation, gradient store and result register
// depends on acwg_pkg, acwg_ram, acwg_div
`timescale 1ns / 1ps
`default_nettype none
module acwg_back
    import acwg_pkg::*;
#(
    parameter int MAX_PATCH = 2048,
    parameter int MAX_MAP   = 4096
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire [CFG_IW-1:0]  i_cfg_idx,
    input  wire [CFG_DW-1:0]  i_cfg_data,
    input  wire               i_item_valid,
    input  t_item             i_item,
    output logic              o_item_ready,
    output logic              o_hold,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output logic              o_out_kind,
    output logic [14:0]       o_patch_row,
    output logic [14:0]       o_patch_col,
    output logic [31:0]       o_grad_value
);
    localparam int AW = (MAX_PATCH > 1) ? $clog2(MAX_PATCH) : 1;
    localparam int IW = (MAX_MAP > 1) ? $clog2(MAX_MAP) : 1;

    t_state r_state, n_state;

    // configuration
    logic [10:0] r_map_width;
    logic [3:0]  r_stride;
    logic [3:0]  r_frows;
    logic [3:0]  r_fcols;
    logic [5:0]  r_chans;

    // map tracking and weight
    logic [31:0]        r_peak_mag;
    logic signed [31:0] r_peak;
    logic [IW-1:0]      r_peak_idx;
    logic [IW-1:0]      r_cnt;
    logic signed [43:0] r_sum;
    logic signed [47:0] r_weight;
    logic               r_neg;
    logic [31:0]        r_mp;
    logic [43:0]        r_ms;
    logic [5:0]         r_mcnt;
    logic [PROD_W-1:0]  r_acc;
    logic [DVS_W-1:0]   r_dm;
    logic [14:0]        r_row;
    logic [14:0]        r_col;

    // patch and store
    logic [AW-1:0]      r_pos;
    logic [AW-1:0]      r_clr;
    logic               r_init;
    logic signed [31:0] r_x;
    logic [63:0]        r_p0;
    logic [47:0]        r_p1;
    logic signed [47:0] r_c;
    logic               r_rd_zero;

    // result register
    logic        r_out_valid;
    logic        r_out_kind;
    logic [14:0] r_out_row;
    logic [14:0] r_out_col;
    logic [31:0] r_out_grad;

    logic        w_pop;
    logic        w_out_free;
    logic        w_out_load;
    logic        w_div_start;
    logic        w_div_busy;
    logic        w_div_done;
    logic [PROD_W-1:0] w_div_quo;
    logic [DVS_W-1:0]  w_div_rem;
    logic [PROD_W-1:0] w_div_num;
    logic [DVS_W-1:0]  w_div_dvs;

    logic              w_ram_we;
    logic [AW-1:0]     w_ram_waddr;
    logic [47:0]       w_ram_wdata;
    logic              w_ram_re;
    logic [AW-1:0]     w_ram_raddr;
    logic [47:0]       w_ram_rdata;

    // gradient store, swept to zero after reset and on a clear command
    acwg_ram #(
        .WIDTH (48),
        .DEPTH (MAX_PATCH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // shared divider: weight quotient, then peak row and column
    acwg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_num),
        .i_divisor  (w_div_dvs),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quo      (w_div_quo),
        .o_rem      (w_div_rem)
    );

    // sample update
    logic [31:0]        w_mag;
    logic signed [44:0] w_sum_ext;
    logic signed [43:0] w_sum_sat;
    assign w_mag     = i_item.value[31] ? 32'(-i_item.value) : 32'(i_item.value);
    assign w_sum_ext = 45'(r_sum) + 45'(i_item.value);
    assign w_sum_sat = (w_sum_ext[44] != w_sum_ext[43])
                     ? (w_sum_ext[44] ? {1'b1, 43'b0} : {1'b0, {43{1'b1}}})
                     : w_sum_ext[43:0];

    // weight operands
    logic signed [32:0] w_d;
    assign w_d = 33'(r_peak) + EPS_Q16;

    // patch size and position
    logic [7:0]     w_rc;
    logic [SZW-1:0] w_prod;
    logic [SZW-1:0] w_size;
    logic [SZW-1:0] w_pos_inc;
    logic [10:0]    w_map_w;
    assign w_rc      = 8'(r_frows) * 8'(r_fcols);
    assign w_prod    = SZW'(w_rc) * SZW'(r_chans);
    assign w_size    = (w_prod > SZW'(MAX_PATCH)) ? SZW'(MAX_PATCH) : w_prod;
    assign w_pos_inc = SZW'(r_pos) + 1'b1;
    assign w_map_w   = (r_map_width == '0) ? 11'd1 : r_map_width;

    // patch product assembly and saturation
    logic [31:0] w_mx;
    logic [47:0] w_mw;
    logic [79:0] w_full;
    logic        w_povf;
    logic [47:0] w_pm;
    logic        w_pneg;
    logic signed [47:0] w_c;
    logic signed [48:0] w_acc49;
    logic signed [47:0] w_new;
    assign w_mx   = r_x[31] ? 32'(-r_x) : 32'(r_x);
    assign w_mw   = r_weight[47] ? 48'(-r_weight) : 48'(r_weight);
    assign w_full = {16'b0, r_p0} + {r_p1, 32'b0};
    assign w_povf = |w_full[79:63];
    assign w_pm   = w_full[63:16];
    assign w_pneg = (r_x[31] != r_weight[47]) && (w_pm != '0);
    always_comb begin
        if (w_pneg) begin
            w_c = (w_povf || w_pm[47]) ? W48_MIN : 48'(-w_pm);
        end else begin
            w_c = (w_povf || w_pm[47]) ? W48_MAX : w_pm;
        end
    end
    assign w_acc49 = 49'(signed'(w_ram_rdata)) + 49'(r_c);
    assign w_new   = (w_acc49[48] != w_acc49[47]) ? (w_acc49[48] ? W48_MIN : W48_MAX)
                   : w_acc49[47:0];

    // entry read divided by the batch size
    logic signed [47:0] w_biased;
    logic signed [40:0] w_q;
    logic [31:0]        w_grad;
    assign w_biased = signed'(w_ram_rdata) + (w_ram_rdata[47] ? 48'sd127 : 48'sd0);
    assign w_q      = 41'(w_biased >>> BATCH_SHIFT);
    assign w_grad   = (w_q[40:31] == '0 || w_q[40:31] == '1) ? w_q[31:0]
                    : (w_q[40] ? 32'h8000_0000 : 32'h7FFF_FFFF);

    // weight from the divider quotient
    logic               w_wovf;
    logic signed [47:0] w_wq;
    assign w_wovf = |w_div_quo[PROD_W-1:47];
    assign w_wq   = r_neg ? (w_wovf ? W48_MIN : -{1'b0, w_div_quo[46:0]})
                          : (w_wovf ? W48_MAX : {1'b0, w_div_quo[46:0]});

    // peak location from quotient and remainder
    logic [19:0] w_row_p;
    logic [14:0] w_col_p;
    assign w_row_p = 20'(w_div_quo[15:0]) * 20'(r_stride);
    assign w_col_p = 15'(w_div_rem[10:0]) * 15'(r_stride);

    // read address
    logic [12:0] w_addr_ext;
    logic        w_in_range;
    assign w_addr_ext = {2'b0, i_item.addr};
    assign w_in_range = w_addr_ext < 13'(MAX_PATCH);

    assign w_out_free   = !r_out_valid || i_out_ready;
    assign w_out_load   = ((r_state == ST_EMIT) || (r_state == ST_R_OUT)) && w_out_free;
    assign o_item_ready = r_state == ST_IDLE;
    assign w_pop        = i_item_valid && o_item_ready;
    assign o_hold       = r_init;

    // next state and store/divider controls
    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        w_div_num   = r_acc;
        w_div_dvs   = r_dm;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_pos;
        w_ram_wdata = w_new;
        w_ram_re    = 1'b0;
        w_ram_raddr = w_addr_ext[AW-1:0];
        unique case (r_state)
            ST_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr;
                w_ram_wdata = '0;
                if (r_clr == AW'(MAX_PATCH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_pop) begin
                    case (i_item.op)
                        OP_SAMPLE: begin
                            if (i_item.last) begin
                                n_state = ST_W_START;
                            end
                        end
                        OP_PATCH: begin
                            if (w_size != '0) begin
                                n_state = ST_P_A;
                            end
                        end
                        OP_READ: begin
                            w_ram_re = w_in_range;
                            n_state  = ST_R_OUT;
                        end
                        default: begin
                            n_state = ST_CLEAR;
                        end
                    endcase
                end
            end
            ST_W_START: begin
                if (r_peak == '0 || r_sum == '0 || w_d == '0) begin
                    n_state = ST_L_DIV;
                end else begin
                    n_state = ST_W_MUL;
                end
            end
            ST_W_MUL: begin
                if (r_mcnt == 6'(MUL_STEPS - 1)) begin
                    n_state = ST_W_DIV;
                end
            end
            ST_W_DIV: begin
                w_div_start = 1'b1;
                n_state     = ST_W_WAIT;
            end
            ST_W_WAIT: begin
                if (w_div_done) begin
                    n_state = ST_L_DIV;
                end
            end
            ST_L_DIV: begin
                w_div_start = 1'b1;
                w_div_num   = PROD_W'(r_peak_idx);
                w_div_dvs   = DVS_W'(w_map_w);
                n_state     = ST_L_WAIT;
            end
            ST_L_WAIT: begin
                if (w_div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_P_A: begin
                w_ram_re    = 1'b1;
                w_ram_raddr = r_pos;
                n_state     = ST_P_B;
            end
            ST_P_B: begin
                n_state = ST_P_C;
            end
            ST_P_C: begin
                n_state = ST_P_D;
            end
            ST_P_D: begin
                w_ram_we = 1'b1;
                n_state  = ST_IDLE;
            end
            ST_R_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width <= 11'd1;
            r_stride    <= 4'd1;
            r_frows     <= 4'd5;
            r_fcols     <= 4'd5;
            r_chans     <= 6'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAP_WIDTH:   r_map_width <= i_cfg_data;
                CFG_CONV_STRIDE: r_stride    <= i_cfg_data[3:0];
                CFG_FILTER_ROWS: r_frows     <= i_cfg_data[3:0];
                CFG_FILTER_COLS: r_fcols     <= i_cfg_data[3:0];
                CFG_CHANNELS:    r_chans     <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // control state: tracking, position, clear sweep, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak_mag  <= '0;
            r_peak      <= '0;
            r_peak_idx  <= '0;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_weight    <= '0;
            r_pos       <= '0;
            r_clr       <= '0;
            r_init      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    if (r_clr == AW'(MAX_PATCH - 1)) begin
                        r_clr  <= '0;
                        r_init <= 1'b0;
                    end else begin
                        r_clr <= r_clr + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (w_pop) begin
                        case (i_item.op)
                            OP_SAMPLE: begin
                                if (w_mag > r_peak_mag) begin
                                    r_peak_mag <= w_mag;
                                    r_peak     <= i_item.value;
                                    r_peak_idx <= r_cnt;
                                end
                                r_sum <= w_sum_sat;
                                if (r_cnt < IW'(MAX_MAP - 1)) begin
                                    r_cnt <= r_cnt + 1'b1;
                                end
                            end
                            OP_PATCH: begin
                                if (SZW'(r_pos) >= w_size) begin
                                    r_pos <= '0;
                                end
                            end
                            OP_CLEAR: begin
                                r_pos <= '0;
                                r_clr <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_W_START: begin
                    if (r_peak == '0 || r_sum == '0) begin
                        r_weight <= '0;
                    end else if (w_d == '0) begin
                        r_weight <= (r_peak[31] != r_sum[43]) ? W48_MIN : W48_MAX;
                    end
                end
                ST_W_WAIT: begin
                    if (w_div_done) begin
                        r_weight <= w_wq;
                    end
                end
                ST_EMIT: begin
                    if (w_out_free) begin
                        r_peak_mag  <= '0;
                        r_peak      <= '0;
                        r_peak_idx  <= '0;
                        r_cnt       <= '0;
                        r_sum       <= '0;
                        r_pos       <= '0;
                    end
                end
                ST_P_D: begin
                    r_pos <= (w_pos_inc >= w_size) ? '0 : r_pos + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_x       <= i_item.value;
                r_rd_zero <= !w_in_range;
            end
            ST_W_START: begin
                r_neg  <= (r_peak[31] != r_sum[43]) != w_d[32];
                r_mp   <= r_peak[31] ? 32'(-r_peak) : 32'(r_peak);
                r_ms   <= r_sum[43] ? 44'(-r_sum) : 44'(r_sum);
                r_dm   <= w_d[32] ? DVS_W'(-w_d) : DVS_W'(w_d);
                r_acc  <= '0;
                r_mcnt <= '0;
            end
            ST_W_MUL: begin
                r_acc  <= {r_acc[PROD_W-2:0], 1'b0} + (r_ms[43] ? PROD_W'(r_mp) : '0);
                r_ms   <= {r_ms[42:0], 1'b0};
                r_mcnt <= r_mcnt + 1'b1;
            end
            ST_L_WAIT: begin
                r_row <= w_row_p[14:0];
                r_col <= w_col_p;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    r_out_kind <= 1'b0;
                    r_out_row  <= r_row;
                    r_out_col  <= r_col;
                    r_out_grad <= '0;
                end
            end
            ST_P_A: begin
                r_p0 <= {32'b0, w_mx} * {32'b0, w_mw[31:0]};
            end
            ST_P_B: begin
                r_p1 <= {16'b0, w_mx} * {32'b0, w_mw[47:32]};
            end
            ST_P_C: begin
                r_c <= w_c;
            end
            ST_R_OUT: begin
                if (w_out_free) begin
                    r_out_kind <= 1'b1;
                    r_out_row  <= '0;
                    r_out_col  <= '0;
                    r_out_grad <= r_rd_zero ? '0 : w_grad;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_kind   = r_out_kind;
    assign o_patch_row  = r_out_row;
    assign o_patch_col  = r_out_col;
    assign o_grad_value = r_out_grad;

    // divider is only started when idle
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_busy)
        else $error("divider started while busy");

    // a location result leaves the map tracking cleared
    a_map_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && w_out_free) |=> (r_sum == '0 && r_cnt == '0))
        else $error("map tracking not cleared after location result");

    // weight quotient is followed by the location division
    a_div_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_W_WAIT && w_div_done) |=> (r_state == ST_L_DIV))
        else $error("location division did not follow weight division");
endmodule
`default_nettype wire
